### design/nrrr_pkg.sv
// ----------------------------------------------------------------------------
// nrrr_pkg
// Shared constants and types for the node roster round robin block.
// ----------------------------------------------------------------------------
package nrrr_pkg;

    // roster geometry
    localparam int NODES  = 16;
    localparam int ADDR_W = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int CNT_W  = $clog2(NODES + 1);

    // field widths
    localparam int ID_W   = 8;
    localparam int NOTE_W = 8;
    localparam int OP_W   = 2;
    localparam int BIT_W  = $clog2(NOTE_W);
    localparam int OUT_CNT_W  = 5;
    localparam int OUT_RANK_W = 5;

    // operation codes
    localparam logic [OP_W-1:0] OP_REG = 2'd0;
    localparam logic [OP_W-1:0] OP_REM = 2'd1;

    // write request into the roster memory
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [ID_W-1:0]   data;
    } t_ram_wr;

endpackage

### design/nrrr_ram.sv
// ----------------------------------------------------------------------------
// nrrr_ram
// Roster slot memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module nrrr_ram
    import nrrr_pkg::*;
(
    input  logic              i_clk,
    input  t_ram_wr           i_wr,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [ID_W-1:0]   o_rd_data
);

    logic [ID_W-1:0] r_mem [NODES];
    logic [ID_W-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // read port, registered
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

### design/nrrr_mod.sv
// ----------------------------------------------------------------------------
// nrrr_mod
// Restoring remainder unit: note modulo roster count, one bit per cycle.
// ----------------------------------------------------------------------------
module nrrr_mod
    import nrrr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [NOTE_W-1:0] i_dividend,
    input  logic [CNT_W-1:0]  i_divisor,
    output logic              o_done,
    output logic [ADDR_W-1:0] o_rem
);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [BIT_W-1:0]  r_bit, n_bit;
    logic [CNT_W-1:0]  r_rem, n_rem;
    logic [NOTE_W-1:0] r_num, n_num;
    logic [CNT_W-1:0]  r_div, n_div;
    logic [CNT_W:0]    trial;

    // one restoring step per cycle, msb first
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_bit  = r_bit;
        n_rem  = r_rem;
        n_num  = r_num;
        n_div  = r_div;
        trial  = {r_rem, r_num[r_bit]};
        if (i_start && !r_busy) begin
            n_busy = 1'b1;
            n_bit  = BIT_W'(NOTE_W - 1);
            n_rem  = '0;
            n_num  = i_dividend;
            n_div  = i_divisor;
        end else if (r_busy) begin
            if (trial >= {1'b0, r_div}) begin
                n_rem = CNT_W'(trial - {1'b0, r_div});
            end else begin
                n_rem = CNT_W'(trial);
            end
            if (r_bit == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_bit = r_bit - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_bit <= n_bit;
        r_rem <= n_rem;
        r_num <= n_num;
        r_div <= n_div;
    end

    assign o_done = r_done;
    // remainder stays below the count, so it fits a slot address
    assign o_rem  = r_rem[ADDR_W-1:0];

endmodule

### design/node_roster_round_robin_top.sv
// ----------------------------------------------------------------------------
// node_roster_round_robin_top
// Roster of node identifiers kept sorted in a slot memory, with note
// ownership assigned round robin over the ascending identifiers.
// ----------------------------------------------------------------------------
// Usage:
//   s channel: one transaction per roster event; tuser carries the operation
//   (register, remove, query), tdata the node identifier and note index.
//   m channel: one status transaction per input transaction: roster count,
//   own rank, should-play flag and owner identifier in tdata, owner-valid
//   in tuser.
//   cfg port: own identifier, written while the block is idle.
// Timing:
//   the slots stay sorted ascending in the first count entries. Each item
//   sweeps the filled slots once through the memory read port (one slot per
//   cycle, inserting or closing the gap in the same pass), then, unless the
//   roster ends up empty, runs the note-modulo-count unit and reads the
//   owner slot. One item is in work at a time: tready returns when the
//   item's status is loaded into the output register.
// Reset clears the roster count (slots beyond the count are never read) and
// sets the own identifier to 1. A finished status waits in the output
// register while the next item is accepted; a stalled receiver holds the
// block only when the following status is ready.
// ----------------------------------------------------------------------------
module node_roster_round_robin_top
    import nrrr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config: own identifier
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,
    // input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [7:0] node_id, [15:8] note
    input  logic [1:0]  i_s_tuser,   // [1:0] op
    // output stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // [4:0] node_count, [9:5] own_rank,
                                     // [10] should_play, [18:11] owner_id, zero pad
    output logic        o_m_tuser    // [0] owner_valid
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SWEEP = 3'd1;
    localparam logic [2:0] S_FIN   = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    logic [2:0]        r_state, n_state;
    logic [ID_W-1:0]   r_own_id;
    logic [OP_W-1:0]   r_op, n_op;
    logic [ID_W-1:0]   r_id, n_id;
    logic [NOTE_W-1:0] r_note, n_note;
    logic [ADDR_W-1:0] r_idx, n_idx;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [ID_W-1:0]   r_hold, n_hold;
    logic              r_swapped, n_swapped;
    logic              r_dup, n_dup;
    logic              r_found, n_found;
    logic [CNT_W-1:0]  r_less, n_less;
    logic              r_own_seen, n_own_seen;

    logic              r_out_valid, n_out_valid;
    logic [OUT_CNT_W-1:0]  r_out_count, n_out_count;
    logic [OUT_RANK_W-1:0] r_out_rank, n_out_rank;
    logic              r_out_play, n_out_play;
    logic [ID_W-1:0]   r_out_owner, n_out_owner;
    logic              r_out_owner_ok, n_out_owner_ok;

    t_ram_wr           ram_wr;
    logic [ADDR_W-1:0] rd_addr;
    logic [ID_W-1:0]   rd_data;
    logic              mod_start;
    logic              mod_done;
    logic [ADDR_W-1:0] mod_rem;

    logic              s_fire;
    logic              ins_ok, rem_ok, ins_done, rem_done;
    logic              last_slot, own_lt, id_is_own, out_free;
    logic [CNT_W-1:0]  new_count;

    // slot memory and remainder unit
    nrrr_ram u_ram (
        .i_clk     (i_clk),
        .i_wr      (ram_wr),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    nrrr_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (r_note),
        .i_divisor  (new_count),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    // decode of the current item
    assign s_fire    = i_s_tvalid && o_s_tready;
    assign ins_ok    = (r_op == OP_REG) && (r_id != '0) && (r_count < CNT_W'(NODES));
    assign rem_ok    = (r_op == OP_REM) && (r_id != '0);
    assign ins_done  = ins_ok && !r_dup;
    assign rem_done  = rem_ok && r_found;
    assign last_slot = ((CNT_W'(r_idx) + CNT_W'(1)) == r_count);
    assign own_lt    = (r_id < r_own_id);
    assign id_is_own = (r_id == r_own_id);
    assign out_free  = !r_out_valid || i_m_tready;
    assign new_count = r_count + CNT_W'(ins_done) - CNT_W'(rem_done);
    assign mod_start = (r_state == S_FIN) && (new_count != '0);

    // memory read address: next slot during the sweep, owner slot afterwards
    always_comb begin
        unique case (r_state)
            S_SWEEP:      rd_addr = r_idx + 1'b1;
            S_DIV, S_OUT: rd_addr = mod_rem;
            default:      rd_addr = '0;
        endcase
    end

    // memory write: sorted insert shifts larger entries up, remove shifts down
    always_comb begin
        ram_wr = '0;
        if (r_state == S_SWEEP) begin
            if (ins_ok && !r_dup && !(rd_data == r_id && !r_swapped)
                    && (r_hold < rd_data)) begin
                ram_wr.en   = 1'b1;
                ram_wr.addr = r_idx;
                ram_wr.data = r_hold;
            end else if (rem_ok && r_found) begin
                ram_wr.en   = 1'b1;
                ram_wr.addr = r_idx - 1'b1;
                ram_wr.data = rd_data;
            end
        end else if (r_state == S_FIN && ins_done) begin
            ram_wr.en   = 1'b1;
            ram_wr.addr = r_count[ADDR_W-1:0];
            ram_wr.data = r_hold;
        end
    end

    // sequencer
    always_comb begin
        n_state        = r_state;
        n_op           = r_op;
        n_id           = r_id;
        n_note         = r_note;
        n_idx          = r_idx;
        n_count        = r_count;
        n_hold         = r_hold;
        n_swapped      = r_swapped;
        n_dup          = r_dup;
        n_found        = r_found;
        n_less         = r_less;
        n_own_seen     = r_own_seen;
        n_out_valid    = r_out_valid && !i_m_tready;
        n_out_count    = r_out_count;
        n_out_rank     = r_out_rank;
        n_out_play     = r_out_play;
        n_out_owner    = r_out_owner;
        n_out_owner_ok = r_out_owner_ok;
        unique case (r_state)
            S_IDLE: begin
                if (s_fire) begin
                    n_op       = i_s_tuser;
                    n_id       = i_s_tdata[7:0];
                    n_note     = i_s_tdata[15:8];
                    n_idx      = '0;
                    n_hold     = i_s_tdata[7:0];
                    n_swapped  = 1'b0;
                    n_dup      = 1'b0;
                    n_found    = 1'b0;
                    n_less     = '0;
                    n_own_seen = 1'b0;
                    n_state    = (r_count == '0) ? S_FIN : S_SWEEP;
                end
            end
            S_SWEEP: begin
                // rank statistics over the old contents
                if (rd_data < r_own_id) begin
                    n_less = r_less + 1'b1;
                end
                if (rd_data == r_own_id) begin
                    n_own_seen = 1'b1;
                end
                // insert: identifier already present is seen before any shift
                if (ins_ok && !r_dup) begin
                    if (rd_data == r_id && !r_swapped) begin
                        n_dup = 1'b1;
                    end else if (r_hold < rd_data) begin
                        n_hold    = rd_data;
                        n_swapped = 1'b1;
                    end
                end
                if (rem_ok && rd_data == r_id) begin
                    n_found = 1'b1;
                end
                if (last_slot) begin
                    n_state = S_FIN;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_FIN: begin
                // fold the change into count and own rank
                n_count = new_count;
                if (ins_done && own_lt) begin
                    n_less = r_less + 1'b1;
                end else if (rem_done && own_lt) begin
                    n_less = r_less - 1'b1;
                end
                if (ins_done && id_is_own) begin
                    n_own_seen = 1'b1;
                end else if (rem_done && id_is_own) begin
                    n_own_seen = 1'b0;
                end
                n_state = (new_count == '0) ? S_OUT : S_DIV;
            end
            S_DIV: begin
                if (mod_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_out_valid    = 1'b1;
                    n_out_count    = OUT_CNT_W'(r_count);
                    n_out_rank     = r_own_seen ? OUT_RANK_W'(r_less) : '1;
                    n_out_play     = (r_count != '0) && r_own_seen
                                     && (r_less == CNT_W'(mod_rem));
                    n_out_owner    = (r_count != '0) ? rd_data : '0;
                    n_out_owner_ok = (r_count != '0);
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_own_id    <= ID_W'(1);
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_own_id <= i_cfg_wdata;
            end
        end
        r_op           <= n_op;
        r_id           <= n_id;
        r_note         <= n_note;
        r_idx          <= n_idx;
        r_hold         <= n_hold;
        r_swapped      <= n_swapped;
        r_dup          <= n_dup;
        r_found        <= n_found;
        r_less         <= n_less;
        r_own_seen     <= n_own_seen;
        r_out_count    <= n_out_count;
        r_out_rank     <= n_out_rank;
        r_out_play     <= n_out_play;
        r_out_owner    <= n_out_owner;
        r_out_owner_ok <= n_out_owner_ok;
    end

    // ports
    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {5'd0, r_out_owner, r_out_play, r_out_rank, r_out_count};
    assign o_m_tuser  = r_out_owner_ok;

endmodule

### tb/tb_node_roster_round_robin_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_node_roster_round_robin_top
// Self-checking bench for the node roster round robin block. A directed
// opening covers the empty roster, zero and duplicate identifiers, a full
// roster and the unused op code. Random phases follow, each setting the
// own identifier first. A roster predictor tracks the identifier set
// and checks every status transaction, while the sender bursts and the
// receiver stalls at random.
// ----------------------------------------------------------------------------
module tb_node_roster_round_robin_top
    import nrrr_pkg::*;
();

    // op codes not named in the package
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam int PHASE_ITEMS = 200;
    localparam int DRAIN_CYCLES = 40;

    // one expected status transaction
    typedef struct packed {
        logic [OUT_CNT_W-1:0]  node_count;
        logic [OUT_RANK_W-1:0] own_rank;
        logic                  should_play;
        logic [ID_W-1:0]       owner_id;
        logic                  owner_valid;
    } t_status;

    // roster predictor and status checker
    class t_roster_predictor;
        logic [ID_W-1:0] slots[NODES];
        logic [ID_W-1:0] own;
        t_status         status_q[$];
        int              errors;

        function new();
            foreach (slots[i]) slots[i] = '0;
            own = 8'd1;
            errors = 0;
        endfunction

        function bit holds(logic [ID_W-1:0] id);
            foreach (slots[i]) if (slots[i] == id) return 1;
            return 0;
        endfunction

        // number of filled slots below id
        function int rank_below(logic [ID_W-1:0] id);
            int r;
            r = 0;
            foreach (slots[i]) if (slots[i] != 0 && slots[i] < id) r++;
            return r;
        endfunction

        function int occupied();
            int c;
            c = 0;
            foreach (slots[i]) if (slots[i] != 0) c++;
            return c;
        endfunction

        // apply one accepted roster event and queue its status
        function void take_event(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                                 logic [NOTE_W-1:0] note);
            t_status s;
            int cnt;
            int rank;
            int tgt;
            s = '0;
            if (op == OP_REG && id != 0 && !holds(id)) begin
                for (int i = 0; i < NODES; i++) begin
                    if (slots[i] == 0) begin
                        slots[i] = id;
                        break;
                    end
                end
            end else if (op == OP_REM && id != 0) begin
                for (int i = 0; i < NODES; i++) begin
                    if (slots[i] == id) begin
                        slots[i] = '0;
                        break;
                    end
                end
            end
            cnt = occupied();
            rank = -1;
            if (own != 0 && holds(own)) rank = rank_below(own);
            if (cnt != 0) begin
                tgt = int'(note) % cnt;
                s.should_play = (rank >= 0 && rank == tgt);
                for (int i = 0; i < NODES; i++) begin
                    if (slots[i] != 0 && rank_below(slots[i]) == tgt) begin
                        s.owner_id = slots[i];
                        s.owner_valid = 1'b1;
                        break;
                    end
                end
            end
            s.node_count = cnt[OUT_CNT_W-1:0];
            s.own_rank = rank[OUT_RANK_W-1:0];
            status_q.push_back(s);
        endfunction

        function void cmp_field(string name, int exp, int act);
            if (exp != act) begin
                $error("%s: expected %0d, got %0d", name, exp, act);
                errors++;
            end
        endfunction

        // compare one status transaction against the oldest expectation
        function void check_status(logic [23:0] d, logic u);
            t_status s;
            if (status_q.size() == 0) begin
                $error("status transaction with no expectation: tdata %h", d);
                errors++;
                return;
            end
            s = status_q.pop_front();
            cmp_field("node_count", s.node_count, d[4:0]);
            cmp_field("own_rank", $signed(s.own_rank), $signed(d[9:5]));
            cmp_field("should_play", s.should_play, d[10]);
            cmp_field("owner_id", s.owner_id, d[18:11]);
            cmp_field("owner_valid", s.owner_valid, u);
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [7:0]  i_cfg_wdata;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [15:0] i_s_tdata;
    logic [1:0]  i_s_tuser;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [23:0] o_m_tdata;
    logic        o_m_tuser;

    t_roster_predictor roster = new();
    int burst_left;
    int pool_base;
    int pool_size;

    node_roster_round_robin_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #2ms;
        $display("** node_roster_round_robin_top: FAILED **");
        $finish;
    end

    // receiver stall pattern: random stretches of four modes
    initial begin
        int mode;
        int len;
        i_m_tready = 1'b0;
        forever begin
            mode = $urandom_range(0, 3);
            len = (mode == 3) ? $urandom_range(1, 20) : $urandom_range(8, 60);
            repeat (len) begin
                @(negedge i_clk);
                case (mode)
                    0: i_m_tready = 1'b1;
                    1: i_m_tready = ($urandom_range(0, 99) < 70);
                    2: i_m_tready = ($urandom_range(0, 99) < 25);
                    default: i_m_tready = 1'b0;
                endcase
            end
        end
    end

    // status monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            roster.check_status(o_m_tdata, o_m_tuser);
    end

    function int new_burst();
        return ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    endfunction

    // drive one roster event and wait until it is accepted
    task automatic send_item(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                             input logic [NOTE_W-1:0] note);
        @(negedge i_clk);
        i_s_tvalid = 1'b1;
        i_s_tuser = op;
        i_s_tdata = {note, id};
        do @(posedge i_clk); while (!o_s_tready);
        roster.take_event(op, id, note);
        burst_left--;
        if (burst_left <= 0) begin
            @(negedge i_clk);
            i_s_tvalid = 1'b0;
            repeat ($urandom_range(0, 12)) @(negedge i_clk);
            burst_left = new_burst();
        end
    endtask

    task automatic go_idle();
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
        while (roster.status_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_own_id(input logic [7:0] value);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_wdata = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        roster.own = value;
    endtask

    // random identifier: mostly from the phase pool, sometimes anywhere or zero
    function logic [ID_W-1:0] pick_id();
        int r;
        r = $urandom_range(0, 99);
        if (r < 6) return '0;
        if (r < 22) return ID_W'($urandom_range(0, 255));
        return ID_W'(pool_base + $urandom_range(0, pool_size - 1));
    endfunction

    function logic [OP_W-1:0] pick_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return OP_REG;
        if (r < 72) return OP_REM;
        if (r < 95) return OP_QUERY;
        return OP_UNUSED;
    endfunction

    // stimulus
    initial begin
        logic [7:0] own_val;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_s_tuser = '0;
        burst_left = new_burst();
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: empty roster, zero ids, duplicates, full roster
        send_item(OP_QUERY, 8'd0, 8'd0);
        send_item(OP_UNUSED, 8'd9, 8'd255);
        send_item(OP_REG, 8'd0, 8'd3);
        send_item(OP_REM, 8'd0, 8'd4);
        send_item(OP_REG, 8'd1, 8'd0);
        send_item(OP_REG, 8'd1, 8'd1);
        send_item(OP_REG, 8'd255, 8'd255);
        send_item(OP_REM, 8'd77, 8'd2);
        send_item(OP_QUERY, 8'd0, 8'd1);
        for (int k = 0; k < NODES - 2; k++)
            send_item(OP_REG, 8'd2 + 8'(k * 17), 8'(k * 37));
        send_item(OP_REG, 8'd200, 8'd128);
        send_item(OP_QUERY, 8'd0, 8'd255);
        send_item(OP_REM, 8'd255, 8'd15);
        send_item(OP_REM, 8'd1, 8'd16);
        go_idle();

        // random phases, each with its own identifier setting
        for (int ph = 0; ph < 4; ph++) begin
            pool_size = $urandom_range(8, 32);
            pool_base = $urandom_range(1, 256 - pool_size);
            case (ph)
                0: own_val = 8'd255;
                1: own_val = 8'($urandom_range(1, 255));
                2: own_val = 8'(pool_base + $urandom_range(0, pool_size - 1));
                default: own_val = 8'd1;
            endcase
            if (ph == 3) pool_base = 1;
            set_own_id(own_val);
            repeat (PHASE_ITEMS)
                send_item(pick_op(), pick_id(), NOTE_W'($urandom_range(0, 255)));
            go_idle();
        end

        if (roster.errors == 0)
            $display("** node_roster_round_robin_top: PASSED **");
        else
            $display("** node_roster_round_robin_top: FAILED **");
        $finish;
    end

endmodule
